[src/wdc_pkg.sv]
// shared types, constants and tables for the waypoint drive controller
package wdc_pkg;

  localparam int QueueDepth = 64;
  localparam int QueueAw = $clog2(QueueDepth);
  localparam int CordicSteps = 16;
  localparam int StepW = $clog2(CordicSteps + 1);

  localparam logic [29:0] CordicGainQ30 = 30'd652032874;
  localparam logic [21:0] PiMicrorad = 22'd3141593;

  localparam logic [2:0] REG_MODE = 3'd0;
  localparam logic [2:0] REG_XY_TOL = 3'd1;
  localparam logic [2:0] REG_YAW_TOL = 3'd2;
  localparam logic [2:0] REG_FWD = 3'd3;
  localparam logic [2:0] REG_ROT = 3'd4;

  localparam logic [1:0] PHASE_TURN = 2'd0;
  localparam logic [1:0] PHASE_DRIVE = 2'd1;
  localparam logic [1:0] PHASE_FINAL = 2'd2;
  localparam logic [1:0] PHASE_STOP = 2'd3;

  typedef struct packed {
    logic        mode;
    logic [23:0] xy_tol;
    logic [14:0] yaw_tol;
    logic [23:0] fwd;
    logic [23:0] rot;
  } cfg_t;

  function automatic logic [31:0] atan_lut(input logic [4:0] i);
    logic [31:0] r;
    case (i)
      5'd0: r = 32'd536870912;  5'd1: r = 32'd316933406;
      5'd2: r = 32'd167458907;  5'd3: r = 32'd85004756;
      5'd4: r = 32'd42667331;   5'd5: r = 32'd21354465;
      5'd6: r = 32'd10679838;   5'd7: r = 32'd5340245;
      5'd8: r = 32'd2670163;    5'd9: r = 32'd1335087;
      5'd10: r = 32'd667544;    5'd11: r = 32'd333772;
      5'd12: r = 32'd166886;    5'd13: r = 32'd83443;
      5'd14: r = 32'd41722;     5'd15: r = 32'd20861;
      5'd16: r = 32'd10430;     5'd17: r = 32'd5215;
      5'd18: r = 32'd2608;      5'd19: r = 32'd1304;
      5'd20: r = 32'd652;       5'd21: r = 32'd326;
      5'd22: r = 32'd163;       5'd23: r = 32'd81;
      5'd24: r = 32'd41;        5'd25: r = 32'd20;
      5'd26: r = 32'd10;        5'd27: r = 32'd5;
      5'd28: r = 32'd3;         5'd29: r = 32'd1;
      5'd30: r = 32'd1;
      default: r = 32'd0;
    endcase
    return r;
  endfunction

endpackage

[src/waypoint_drive_controller_unit.sv]
// waypoint drive controller top level: queue, sequencer and command logic
//
// Input stream s_axis: opcode in tuser, pos_x/pos_y/heading in tdata. A beat
// with opcode 0 loads a waypoint into a 64-entry queue (full queue drops it)
// and gives no output. A beat with opcode 1 is a pose update and gives one
// output beat on m_axis: linear_cmd/angular_cmd in tdata, drive_phase,
// waypoint_reached, route_done in tuser.
// A pose update runs one 16-step cordic pass against the head waypoint, a
// second read and cordic pass if the head was popped and the queue is not
// empty, and a 25-step divide for curved drive in speed mode.
// Loads are taken one per cycle, back to back, while no result waits in the output register.
// One item is worked at a time: s_axis_tready is low while busy and while a
// result waits in the output register; a stalled receiver holds the result.
// The next beat is taken from the cycle after the output beat is accepted.
// Synchronous reset empties the queue and restores register defaults; the
// queue contents are not cleared. Configuration writes on the wr_en port are
// for the user to make only while the block is idle; the block does not enforce it.
module waypoint_drive_controller_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [79:0] s_axis_tdata,  // pos_x[30:0], pos_y[61:31], heading[77:62]
  input  logic        s_axis_tuser,  // opcode
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata,  // linear_cmd[30:0], angular_cmd[55:31]
  output logic [3:0]  m_axis_tuser,  // drive_phase[1:0], waypoint_reached, route_done
  input  logic        wr_en,
  input  logic [2:0]  wr_index,
  input  logic [23:0] wr_data
);
  import wdc_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0, S_RD = 3'd1, S_CORD = 3'd2, S_EVAL = 3'd3,
                         S_DIV = 3'd4, S_OUT = 3'd5, S_MUL = 3'd6, S_REREAD = 3'd7;

  cfg_t cfg;
  logic [2:0] state;
  logic [QueueAw-1:0] head;
  logic [QueueAw:0] count;
  logic signed [30:0] px, py;
  logic signed [15:0] ph;
  logic reached;
  logic pass2;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mode <= 1'b0; cfg.xy_tol <= '0; cfg.yaw_tol <= '0;
      cfg.fwd <= 24'd100000; cfg.rot <= 24'd523598;
    end else if (wr_en) begin
      case (wr_index)
        REG_MODE: cfg.mode <= wr_data[0];
        REG_XY_TOL: cfg.xy_tol <= wr_data;
        REG_YAW_TOL: cfg.yaw_tol <= wr_data[14:0];
        REG_FWD: cfg.fwd <= wr_data;
        REG_ROT: cfg.rot <= wr_data;
        default: ;
      endcase
    end
  end

  logic acc;
  assign s_axis_tready = (state == S_IDLE) && !m_axis_tvalid;
  assign acc = s_axis_tvalid && s_axis_tready;

  logic load;
  logic [QueueAw-1:0] addr;
  logic signed [30:0] wx, wy;
  logic signed [15:0] wyaw;
  logic [QueueAw:0] tail;
  assign load = acc && !s_axis_tuser && (count < (QueueAw+1)'(QueueDepth));
  assign tail = {1'b0, head} + count;
  assign addr = load ? tail[QueueAw-1:0] : head;

  wdc_ram #(.Width(31), .Depth(QueueDepth)) u_ram_x (
    .clk(clk), .we(load), .addr(addr), .wdata(s_axis_tdata[30:0]), .rdata(wx));
  wdc_ram #(.Width(31), .Depth(QueueDepth)) u_ram_y (
    .clk(clk), .we(load), .addr(addr), .wdata(s_axis_tdata[61:31]), .rdata(wy));
  wdc_ram #(.Width(16), .Depth(QueueDepth)) u_ram_yaw (
    .clk(clk), .we(load), .addr(addr), .wdata(s_axis_tdata[77:62]), .rdata(wyaw));

  logic cstart, cbusy;
  logic signed [35:0] mraw;
  logic [31:0] zang;
  logic signed [32:0] dxs, dys;
  assign dxs = 33'(wx) - 33'(px);
  assign dys = 33'(wy) - 33'(py);
  assign cstart = (state == S_RD);
  wdc_cordic u_cordic (.clk(clk), .rst(rst), .start(cstart), .dx(dxs), .dy(dys),
    .busy(cbusy), .mag_raw(mraw), .ang(zang));

  // evaluation values
  logic zero_vec;
  logic [33:0] meas_dist;
  logic signed [15:0] alpha, yawd;
  logic [15:0] aa, ay;
  logic [65:0] mprod;
  logic [31:0] zr;
  logic signed [15:0] bearing;
  always_ff @(posedge clk) if (cstart) zero_vec <= (dxs == 0) && (dys == 0);
  assign mprod = (mraw < 0) ? '0 : 66'(mraw[34:0]) * 66'(CordicGainQ30) + 66'h2000_0000;
  assign zr = zang + 32'h8000;
  assign bearing = zero_vec ? 16'sd0 : zr[31:16];
  assign alpha = bearing - ph;
  assign yawd = ph - wyaw;
  assign aa = alpha[15] ? -alpha : alpha;
  assign ay = yawd[15] ? -yawd : yawd;

  logic [33:0] dist_r;
  logic signed [15:0] alpha_r, yawd_r;
  logic [15:0] aa_r;
  assign meas_dist = zero_vec ? '0 : mprod[63:30];

  // divider
  logic dstart, dbusy;
  logic div_need;
  logic [24:0] q;
  logic [39:0] m1;
  logic [63:0] num;
  logic [46:0] den;
  assign num = 64'(m1) * 64'(PiMicrorad);
  assign den = {13'd0, dist_r} << 15;
  assign div_need = !cfg.mode && dist_r > 34'(cfg.xy_tol) && aa_r <= 16'(cfg.yaw_tol);
  wdc_div u_div (.clk(clk), .rst(rst), .start(dstart), .num(num), .den(den),
    .busy(dbusy), .quo(q));

  always_ff @(posedge clk) begin
    if (rst) begin
      dstart <= 1'b0;
    end else begin
      dstart <= (state == S_MUL) && div_need;
    end
  end

  logic [30:0] lin;
  logic signed [24:0] ang_o;
  logic [1:0] phase;
  logic done;
  logic signed [24:0] rot_s;
  assign rot_s = 25'(cfg.rot);

  always_comb begin
    done = (count == 0);
    lin = '0;
    ang_o = '0;
    phase = PHASE_STOP;
    if (!done) begin
      if (dist_r > 34'(cfg.xy_tol)) begin
        if (aa_r > 16'(cfg.yaw_tol)) begin
          phase = PHASE_TURN;
          ang_o = cfg.mode ? 25'(alpha_r) : (alpha_r < 0 ? -rot_s : rot_s);
        end else begin
          phase = PHASE_DRIVE;
          if (cfg.mode) begin
            lin = (dist_r > 34'h7FFF_FFFF) ? 31'h7FFF_FFFF : dist_r[30:0];
            ang_o = 25'(alpha_r);
          end else begin
            lin = 31'(cfg.fwd);
            ang_o = (q > 25'(cfg.rot)) ? rot_s : q;
            if (alpha_r < 0) ang_o = -ang_o;
          end
        end
      end else begin
        phase = PHASE_FINAL;
        ang_o = cfg.mode ? 25'(yawd_r) : (yawd_r < 0 ? rot_s : -rot_s);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE; head <= '0; count <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) m_axis_tvalid <= 1'b0;
      case (state)
        S_IDLE: if (acc) begin
          px <= s_axis_tdata[30:0]; py <= s_axis_tdata[61:31];
          ph <= s_axis_tdata[77:62];
          reached <= 1'b0; pass2 <= 1'b0;
          if (load) count <= count + 1'b1;
          if (s_axis_tuser) state <= (count == 0) ? S_OUT : S_RD;
        end
        // new head address is registered into the rams here
        S_REREAD: state <= S_RD;
        S_RD: state <= S_CORD;
        S_CORD: if (!cbusy) state <= S_EVAL;
        S_EVAL: begin
          dist_r <= meas_dist; alpha_r <= alpha; yawd_r <= yawd; aa_r <= aa;
          if (!pass2 && meas_dist < 34'(cfg.xy_tol) && ay < 16'(cfg.yaw_tol)) begin
            reached <= 1'b1; pass2 <= 1'b1;
            head <= head + 1'b1; count <= count - 1'b1;
            state <= (count == 1) ? S_OUT : S_REREAD;
          end else begin
            state <= S_MUL;
          end
        end
        S_MUL: begin
          m1 <= 40'(aa_r) * 40'(cfg.fwd);
          if (div_need) state <= S_DIV;
          else state <= S_OUT;
        end
        S_DIV: if (!dstart && !dbusy) state <= S_OUT;
        S_OUT: begin
          m_axis_tdata <= {ang_o, lin};
          m_axis_tuser <= {done, reached, phase};
          m_axis_tvalid <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

[src/wdc_ram.sv]
// generic single-port ram with registered read
module wdc_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] addr,
  input  logic [Width-1:0]         wdata,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule

[src/wdc_cordic.sv]
// iterative vectoring cordic: magnitude (unscaled) and 32-bit binary angle
module wdc_cordic (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [32:0] dx,
  input  logic signed [32:0] dy,
  output logic               busy,
  output logic signed [35:0] mag_raw,
  output logic [31:0]        ang
);
  import wdc_pkg::*;

  logic signed [35:0] x, y;
  logic [31:0]        z;
  logic [StepW-1:0]   step;
  logic signed [35:0] xs, ys;
  logic [4:0]         sh;

  assign sh = 5'(step);
  assign xs = x >>> sh;
  assign ys = y >>> sh;
  assign mag_raw = x;
  assign ang = z;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= '0;
    end else if (start) begin
      busy <= 1'b1;
      step <= '0;
      if (dx < 0) begin
        if (dy >= 0) begin
          x <= 36'(dy); y <= -36'(dx); z <= 32'h4000_0000;
        end else begin
          x <= -36'(dy); y <= 36'(dx); z <= 32'hC000_0000;
        end
      end else begin
        x <= 36'(dx); y <= 36'(dy); z <= '0;
      end
    end else if (busy) begin
      if (y < 0) begin
        x <= x - ys; y <= y + xs; z <= z - atan_lut(sh);
      end else begin
        x <= x + ys; y <= y - xs; z <= z + atan_lut(sh);
      end
      if (step == StepW'(CordicSteps - 1)) busy <= 1'b0;
      step <= step + 1'b1;
    end
  end
endmodule

[src/wdc_div.sv]
// restoring divider, one quotient bit a cycle, quotient saturates at 25 bits
module wdc_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] num,
  input  logic [46:0] den,
  output logic        busy,
  output logic [24:0] quo
);
  logic [63:0] rem;
  logic [24:0] q;
  logic [4:0]  cnt;
  logic        ovf;
  logic [71:0] trial;

  // quotient bits 24..0; overflow if num >= den<<25
  assign trial = {47'd0, 25'(0)} | ({25'd0, den} << cnt);
  assign quo = ovf ? '1 : q;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
      rem <= num;
      q <= '0;
      cnt <= 5'd24;
      ovf <= ({8'd0, num} >= ({25'd0, den} << 25));
    end else if (busy) begin
      if ({8'd0, rem} >= trial) begin
        rem <= rem - trial[63:0];
        q[cnt] <= 1'b1;
      end
      if (cnt == 5'd0) busy <= 1'b0;
      cnt <= cnt - 1'b1;
    end
  end
endmodule

[src/wdc_checker.sv]
// port-level checks for the waypoint drive controller, bound to the top level
module wdc_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        s_axis_tuser,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [55:0] m_axis_tdata,
  input logic [3:0]  m_axis_tuser
);
  import wdc_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output beat changed while stalled");
  a_noacc_out: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !s_axis_tready)
    else $error("input taken while result pending");
  a_done_stop: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser[3] |-> m_axis_tuser[1:0] == PHASE_STOP && m_axis_tdata == '0)
    else $error("done beat not a stop command");
  a_load_quiet: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready && !s_axis_tuser |=> !m_axis_tvalid)
    else $error("load produced a result");
endmodule

bind waypoint_drive_controller_unit wdc_checker u_wdc_checker (.*);

[dv/waypoint_drive_controller_unit_tb.sv]
// self-checking testbench for the waypoint drive controller top level
`timescale 1ns / 1ps

module waypoint_drive_controller_unit_tb;
  import wdc_pkg::*;

  localparam logic [2:0] RegUnused = 3'd7;
  localparam bit OpLoad = 1'b0;
  localparam bit OpPose = 1'b1;
  localparam int SettleCycles = 120;
  localparam int WatchdogLimit = 40000;
  localparam int RandomPerPhase = 94;

  typedef struct {
    logic [30:0]        lin;
    logic signed [24:0] ang;
    logic [1:0]         phase;
    logic               reached;
    logic               done;
  } drive_cmd_t;

  typedef struct {
    bit                 op;
    int                 x;
    int                 y;
    int                 h;
    bit                 known;
    int                 lin;
    int                 ang;
    logic [1:0]         phase;
    bit                 reached;
    bit                 done;
  } vector_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [79:0] s_axis_tdata = '0;
  logic s_axis_tuser = 1'b0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [55:0] m_axis_tdata;
  logic [3:0] m_axis_tuser;
  logic wr_en = 1'b0;
  logic [2:0] wr_index = '0;
  logic [23:0] wr_data = '0;

  always #4 clk = ~clk;

  waypoint_drive_controller_unit DUT (.*);

  // predictor state
  logic signed [30:0] wp_x [QueueDepth];
  logic signed [15:0] wp_yaw [QueueDepth];
  logic signed [30:0] wp_y [QueueDepth];
  int unsigned q_head, q_count;
  cfg_t cfg;

  drive_cmd_t cmd_queue[$];
  int mismatches = 0;
  int poses_sent = 0, cmds_seen = 0, reach_seen = 0, full_drops = 0;
  int phase_hits [4];
  int idle_pct = 0, stall_pct = 0;
  int quiet_cycles = 0;

  function automatic void cordic_vector(input longint dx, input longint dy,
                                        output longint unsigned mag,
                                        output logic signed [15:0] bearing);
    longint x, y, t, nx, ny;
    logic [31:0] z;
    x = dx; y = dy; z = '0;
    if (dx == 0 && dy == 0) begin
      mag = 0;
      bearing = '0;
      return;
    end
    // pre-rotate into the right half plane
    if (x < 0) begin
      if (y >= 0) begin
        t = x; x = y; y = -t; z = 32'h4000_0000;
      end else begin
        t = x; x = -y; y = t; z = 32'hC000_0000;
      end
    end
    for (int i = 0; i < CordicSteps; i++) begin
      if (y < 0) begin
        nx = x - (y >>> i);
        ny = y + (x >>> i);
        z = z - atan_lut(5'(i));
      end else begin
        nx = x + (y >>> i);
        ny = y - (x >>> i);
        z = z + atan_lut(5'(i));
      end
      x = nx;
      y = ny;
    end
    if (x < 0) x = 0;
    mag = (longint'(x) * longint'(CordicGainQ30) + 64'h2000_0000) >> 30;
    bearing = 16'((z + 32'h8000) >> 16);
  endfunction

  function automatic void measure_head(input logic signed [30:0] px,
                                       input logic signed [30:0] py,
                                       input logic signed [15:0] ph,
                                       output longint unsigned dist_um,
                                       output logic signed [15:0] yaw_err,
                                       output logic signed [15:0] alpha);
    logic signed [15:0] bearing;
    cordic_vector(longint'(wp_x[q_head]) - longint'(px),
                  longint'(wp_y[q_head]) - longint'(py), dist_um, bearing);
    yaw_err = ph - wp_yaw[q_head];
    alpha = bearing - ph;
  endfunction

  // advances the predicted queue; returns 1 with a command for pose updates
  function automatic bit predict_drive(input bit op, input logic signed [30:0] px,
                                       input logic signed [30:0] py,
                                       input logic signed [15:0] ph,
                                       output drive_cmd_t cmd);
    longint unsigned dist_um, quo;
    logic signed [15:0] yaw_err, alpha;
    longint abs_yaw, abs_alpha, rot;
    cmd = '{lin: '0, ang: '0, phase: PHASE_STOP, reached: 1'b0, done: 1'b0};
    rot = longint'(cfg.rot);
    if (op == OpLoad) begin
      if (q_count < QueueDepth) begin
        wp_x[(q_head + q_count) % QueueDepth] = px;
        wp_y[(q_head + q_count) % QueueDepth] = py;
        wp_yaw[(q_head + q_count) % QueueDepth] = ph;
        q_count++;
      end else begin
        full_drops++;
      end
      return 1'b0;
    end
    if (q_count != 0) begin
      measure_head(px, py, ph, dist_um, yaw_err, alpha);
      abs_yaw = yaw_err < 0 ? -longint'(yaw_err) : longint'(yaw_err);
      if (dist_um < cfg.xy_tol && abs_yaw < cfg.yaw_tol) begin
        q_head = (q_head + 1) % QueueDepth;
        q_count--;
        cmd.reached = 1'b1;
        if (q_count != 0) measure_head(px, py, ph, dist_um, yaw_err, alpha);
      end
    end
    if (q_count == 0) begin
      cmd.phase = PHASE_STOP;
      cmd.done = 1'b1;
      return 1'b1;
    end
    abs_alpha = alpha < 0 ? -longint'(alpha) : longint'(alpha);
    if (dist_um > cfg.xy_tol) begin
      if (abs_alpha > cfg.yaw_tol) begin
        cmd.phase = PHASE_TURN;
        cmd.ang = cfg.mode ? 25'(alpha) : 25'(alpha < 0 ? -rot : rot);
      end else begin
        cmd.phase = PHASE_DRIVE;
        if (cfg.mode) begin
          cmd.lin = dist_um > 64'h7FFF_FFFF ? 31'h7FFF_FFFF : 31'(dist_um);
          cmd.ang = 25'(alpha);
        end else begin
          quo = (longint'(abs_alpha) * cfg.fwd * PiMicrorad) / (dist_um * 32768);
          if (quo > cfg.rot) quo = cfg.rot;
          cmd.lin = 31'(cfg.fwd);
          cmd.ang = alpha < 0 ? 25'(-longint'(quo)) : 25'(quo);
        end
      end
    end else begin
      cmd.phase = PHASE_FINAL;
      cmd.ang = cfg.mode ? 25'(yaw_err) : 25'(yaw_err < 0 ? rot : -rot);
    end
    return 1'b1;
  endfunction

  // result side: random stalls and compare against the oldest expectation
  always @(posedge clk) begin
    m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
    if (!rst && (m_axis_tvalid && m_axis_tready || s_axis_tvalid && s_axis_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      cmds_seen++;
      if (cmd_queue.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected beat: tdata=%h tuser=%h", m_axis_tdata, m_axis_tuser);
      end else begin
        drive_cmd_t exp_cmd;
        exp_cmd = cmd_queue.pop_front();
        if (m_axis_tdata[30:0] !== exp_cmd.lin || m_axis_tdata[55:31] !== exp_cmd.ang ||
            m_axis_tuser[1:0] !== exp_cmd.phase || m_axis_tuser[2] !== exp_cmd.reached ||
            m_axis_tuser[3] !== exp_cmd.done) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch: exp lin=%0d ang=%0d ph=%0d rch=%0b dn=%0b",
                     exp_cmd.lin, exp_cmd.ang, exp_cmd.phase, exp_cmd.reached,
                     exp_cmd.done);
            $display("          got lin=%0d ang=%0d ph=%0d rch=%0b dn=%0b",
                     m_axis_tdata[30:0], $signed(m_axis_tdata[55:31]), m_axis_tuser[1:0],
                     m_axis_tuser[2], m_axis_tuser[3]);
          end
        end else if (exp_cmd.reached) begin
          reach_seen++;
        end
        if (exp_cmd.phase == PHASE_STOP || !exp_cmd.done) phase_hits[exp_cmd.phase]++;
      end
    end
  end

  always @(posedge clk) begin
    if (quiet_cycles >= WatchdogLimit) begin
      $display("watchdog: no beat for %0d cycles", WatchdogLimit);
      $display("status: fail");
      $finish;
    end
  end

  // starts at a clock edge, returns at the edge where the beat is taken
  task automatic send_item(input bit op, input logic signed [30:0] px,
                           input logic signed [30:0] py, input logic signed [15:0] ph,
                           input bit known, input drive_cmd_t typed_cmd);
    drive_cmd_t cmd;
    if ($urandom_range(0, 99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= op;
    s_axis_tdata <= {2'b00, ph, py, px};
    do @(posedge clk); while (!s_axis_tready);
    if (op == OpPose) poses_sent++;
    if (predict_drive(op, px, py, ph, cmd))
      cmd_queue.push_back(known ? typed_cmd : cmd);
  endtask

  task automatic send_random(input bit op, input logic signed [30:0] px,
                             input logic signed [30:0] py, input logic signed [15:0] ph);
    send_item(op, px, py, ph, 1'b0, '{lin: '0, ang: '0, phase: '0, reached: 1'b0, done: 1'b0});
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (cmd_queue.size() != 0) @(posedge clk);
  endtask

  task automatic write_cfg(input logic [2:0] idx, input logic [23:0] val);
    wr_en <= 1'b1;
    wr_index <= idx;
    wr_data <= val;
    @(posedge clk);
    wr_en <= 1'b0;
    case (idx)
      REG_MODE: cfg.mode = val[0];
      REG_XY_TOL: cfg.xy_tol = val;
      REG_YAW_TOL: cfg.yaw_tol = val[14:0];
      REG_FWD: cfg.fwd = val;
      REG_ROT: cfg.rot = val;
      default: ;
    endcase
  endtask

  task automatic set_all(input logic mode, input logic [23:0] xy, input logic [14:0] yaw,
                         input logic [23:0] fwd, input logic [23:0] rot);
    drain_results();
    // a trailing load may still be in flight
    repeat (SettleCycles) @(posedge clk);
    write_cfg(REG_MODE, {23'd0, mode});
    write_cfg(REG_XY_TOL, xy);
    write_cfg(REG_YAW_TOL, {9'd0, yaw});
    write_cfg(REG_FWD, fwd);
    write_cfg(REG_ROT, rot);
  endtask

  function automatic logic signed [30:0] near(input logic signed [30:0] c, input int unsigned r);
    return 31'(longint'(c) + longint'($urandom_range(0, 2 * r)) - longint'(r));
  endfunction

  function automatic int unsigned pick_radius();
    case ($urandom_range(0, 4))
      0: return 0;
      1: return cfg.xy_tol / 2;
      2: return cfg.xy_tol + 10;
      3: return 4 * cfg.xy_tol + 1000;
      default: return 1000000;
    endcase
  endfunction

  task automatic random_phase(input int items, input bool_fill);
    logic signed [30:0] bx, by;
    logic signed [15:0] bh;
    int sent, k;
    sent = 0;
    if (bool_fill) begin
      // overfill the queue, then walk it empty with exact poses
      for (int i = 0; i < QueueDepth + 3; i++)
        send_random(OpLoad, 31'($urandom), 31'($urandom), 16'($urandom));
      while (q_count != 0 && sent < 70) begin
        send_random(OpPose, wp_x[q_head], wp_y[q_head], wp_yaw[q_head]);
        sent++;
      end
    end
    while (sent < items) begin
      if (sent == items / 2) drain_results();
      k = $urandom_range(0, 99);
      if (k < 15) begin
        send_random(k < 5 ? OpLoad : OpPose, 31'($urandom), 31'($urandom), 16'($urandom));
        sent++;
      end else if (k < 35 || q_count == 0) begin
        bx = $urandom_range(0, 1) ? 31'($urandom) : near('0, 3000000);
        by = $urandom_range(0, 1) ? 31'($urandom) : near('0, 3000000);
        send_random(OpLoad, bx, by, 16'($urandom));
        sent++;
      end else begin
        bh = 16'(near(31'(wp_yaw[q_head]), $urandom_range(0, 1) ? cfg.yaw_tol : 40000));
        send_random(OpPose, near(wp_x[q_head], pick_radius()),
                    near(wp_y[q_head], pick_radius()), bh);
        sent++;
      end
    end
  endtask

  vector_row_t vectors [] = '{
    '{OpPose, 0, 0, 0, 1, 0, 0, PHASE_STOP, 0, 1},
    '{OpLoad, 1000, 0, 0, 0, 0, 0, PHASE_STOP, 0, 0},
    '{OpPose, 0, 0, 0, 0, 0, 0, PHASE_STOP, 0, 0},
    '{OpPose, 1000, 0, 0, 1, 0, -523598, PHASE_FINAL, 0, 0},
    '{OpPose, 0, 0, 32767, 1, 0, -523598, PHASE_TURN, 0, 0},
    '{OpPose, 0, 0, -32768, 1, 0, -523598, PHASE_TURN, 0, 0},
    '{OpPose, 0, 0, 16384, 1, 0, -523598, PHASE_TURN, 0, 0},
    '{OpLoad, -1073741824, 1073741823, -32768, 0, 0, 0, PHASE_STOP, 0, 0},
    '{OpPose, 1073741823, -1073741824, 32767, 0, 0, 0, PHASE_STOP, 0, 0},
    '{OpPose, -1073741824, -1073741824, 0, 0, 0, 0, PHASE_STOP, 0, 0},
    '{OpPose, 1073741823, 1073741823, -32768, 0, 0, 0, PHASE_STOP, 0, 0},
    '{OpPose, 2000, 500, 100, 0, 0, 0, PHASE_STOP, 0, 0},
    '{OpPose, 1000, -3, 0, 0, 0, 0, PHASE_STOP, 0, 0},
    '{OpPose, -5000, -20, 2, 0, 0, 0, PHASE_STOP, 0, 0},
    '{OpPose, 500, 400, 8000, 0, 0, 0, PHASE_STOP, 0, 0}
  };

  initial begin
    cfg = '{mode: 1'b0, xy_tol: '0, yaw_tol: '0, fwd: 24'd100000, rot: 24'd523598};
    q_head = 0;
    q_count = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (vectors[i])
      send_item(vectors[i].op, 31'(vectors[i].x), 31'(vectors[i].y), 16'(vectors[i].h),
                vectors[i].known,
                '{lin: 31'(vectors[i].lin), ang: 25'(vectors[i].ang), phase: vectors[i].phase,
                  reached: vectors[i].reached, done: vectors[i].done});
    drain_results();
    write_cfg(RegUnused, 24'hFFFFFF);

    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: set_all(1'b0, 24'd5000, 15'd500, 24'($urandom), 24'($urandom));
        1: set_all(1'b1, 24'hFFFFFF, 15'h7FFF, 24'hFFFFFF, 24'hFFFFFF);
        2: set_all(1'b0, 24'd0, 15'd0, 24'd0, 24'd0);
        3: set_all(1'b1, 24'd20000, 15'd2000, 24'($urandom), 24'($urandom));
        default: set_all(1'b0, 24'($urandom_range(1, 200000)), 15'($urandom),
                         24'hFFFFFF, 24'($urandom));
      endcase
      case (ph % 4)
        0: begin idle_pct = 0; stall_pct = 0; end
        1: begin idle_pct = 72; stall_pct = 0; end
        2: begin idle_pct = 0; stall_pct = 72; end
        default: begin idle_pct = 36; stall_pct = 36; end
      endcase
      random_phase(RandomPerPhase, ph == 0);
    end

    drain_results();
    stall_pct = 0;
    repeat (SettleCycles) @(posedge clk);
    $display("covered %0d pose updates and %0d commands (%0d reaches, %0d dropped loads)",
             poses_sent, cmds_seen, reach_seen, full_drops);
    $display("phases turn/drive/final/stop: %0d/%0d/%0d/%0d, mismatches %0d",
             phase_hits[0], phase_hits[1], phase_hits[2], phase_hits[3], mismatches);
    if (mismatches == 0 && cmd_queue.size() == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
